### hw/rtl/nonoverlapping_substring_matcher_defines.svh
// assertion macros for the substring matcher
// used by the top level only, no other dependencies
`ifndef NONOVERLAPPING_SUBSTRING_MATCHER_DEFINES_SVH
`define NONOVERLAPPING_SUBSTRING_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NSM_ASSERT_NOW(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define NSM_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NSM_ASSERT_NOW(lbl, clock, rstn, ante, cons)
`define NSM_ASSERT_NEXT(lbl, clock, rstn, ante, cons)
`endif

`endif

### hw/rtl/nsm_pkg.sv
// shared types, constants and the case fold function of the substring matcher
// no dependencies
`default_nettype none

package nsm_pkg;

	localparam int BYTE_W      = 8;
	localparam int QUERY_BYTES = 16;
	localparam int LEN_W       = 5;
	localparam int OUT_W       = 24;
	localparam logic [OUT_W-1:0] COUNT_MAX = {OUT_W{1'b1}};

	typedef enum logic [1:0] {
		REG_CASE_SENSITIVE = 2'd0,
		REG_QUERY_LENGTH   = 2'd1,
		REG_QUERY_LOW      = 2'd2,
		REG_QUERY_HIGH     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic case_sens;
		logic active;
	} cell_ctrl_t;

	typedef struct packed {
		logic             eot;
		logic [OUT_W-1:0] count;
		logic [OUT_W-1:0] start;
		logic             match;
	} out_word_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
		input logic case_sens);
		logic [BYTE_W-1:0] r;
		r = b;
		if (!case_sens && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/nsm_cell.sv
// one window cell: holds a text byte and compares the byte entering it
// depends on nsm_pkg
`default_nettype none

module nsm_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  nsm_pkg::cell_ctrl_t         ctrl,
	input  wire [nsm_pkg::BYTE_W-1:0]   byte_in,
	input  wire [nsm_pkg::BYTE_W-1:0]   query_byte,
	output logic [nsm_pkg::BYTE_W-1:0]  byte_out,
	output logic                        eq
);

	logic [nsm_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			// end of text empties the window once this byte is compared
			byte_q <= ctrl.clear ? '0 : byte_in;
		end
	end

	assign byte_out = byte_q;
	assign eq = !ctrl.active ||
		(nsm_pkg::fold_byte(byte_in, ctrl.case_sens) ==
		 nsm_pkg::fold_byte(query_byte, ctrl.case_sens));

endmodule

`default_nettype wire

### hw/rtl/nsm_skid.sv
// two-entry output buffer: output register plus skid register
// depends on nsm_pkg
`default_nettype none

module nsm_skid (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  nsm_pkg::out_word_t  in_word,
	output logic                out_valid,
	input  wire                 out_ready,
	output nsm_pkg::out_word_t  out_word
);

	logic               out_valid_q;
	logic               skid_valid_q;
	nsm_pkg::out_word_t out_word_q;
	nsm_pkg::out_word_t skid_word_q;
	logic               take;
	logic               put;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign take      = out_valid_q && out_ready;
	assign put       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (put) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_word_q <= skid_word_q;
			end
		end else if (put) begin
			if (!out_valid_q || take) begin
				out_word_q <= in_word;
			end else begin
				skid_word_q <= in_word;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nonoverlapping_substring_matcher.sv
// top level of the non-overlapping substring matcher: config port, cell row, scan state
// depends on nsm_pkg, nsm_cell, nsm_skid and the defines header
`default_nettype none

// The matcher takes one text byte per word on the slave stream and gives one result word
// per byte on the master stream: a match flag, the start position of a match ending at
// that byte, and the running match count of the text, saturating at 2^24-1. A row of
// MAX_QUERY cells holds the latest text bytes; each cycle the accepted byte shifts into
// the row and every cell compares the byte entering it against its query byte, so the
// whole window is checked in parallel. A byte can be accepted in every cycle while the skid
// register is empty, and when the output register is free its result is written straight
// into it; the rate of one byte per cycle is set by the combinational compare across the
// cell row. A two-entry output buffer keeps input flowing while one result waits. After a
// match, no new match may end in the next query_length-1 bytes. A word with tlast set ends
// the text and clears window, position, skip and count. Configuration goes through the
// 64-bit APB-style port, registers at byte addresses 0, 8, 16, 24; write it only while the
// block is idle. No clearing pass follows reset.
module nonoverlapping_substring_matcher #(
	parameter int MAX_QUERY     = 16,
	parameter int POSITION_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	// apb-style configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// text in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // text_byte
	input  wire         s_tlast,   // last
	// results out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // match, match_start[23:0], match_count[23:0], zero fill
	output logic        m_tlast    // end_of_text
);

	localparam int LW = nsm_pkg::LEN_W;
	localparam int OW = nsm_pkg::OUT_W;

	// configuration registers
	logic          case_sens_q;
	logic [LW-1:0] query_len_q;
	logic [63:0]   query_low_q;
	logic [63:0]   query_high_q;

	// scan state
	logic [POSITION_BITS-1:0] pos_q;
	logic [3:0]               skip_q;
	logic [OW-1:0]            count_q;
	logic [LW-1:0]            seen_q;

	logic                     cfg_wr;
	nsm_pkg::reg_idx_t        cfg_idx;
	logic                     accept;
	logic [LW-1:0]            len_c;
	logic [LW-1:0]            seen_next;
	logic                     hit;
	logic [POSITION_BITS-1:0] start_full;
	logic [63:0]              start_ext;
	logic [OW-1:0]            count_next;
	logic [3:0]               skip_next;
	logic [MAX_QUERY-1:0]     eq_vec;
	logic [7:0]               chain [MAX_QUERY];
	logic [7:0]               qbytes [nsm_pkg::QUERY_BYTES];
	nsm_pkg::out_word_t       res_word;
	nsm_pkg::out_word_t       out_word;

	// ---------------------------------------------------------------- config port
	assign pready  = 1'b1;
	assign cfg_idx = nsm_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sens_q  <= 1'b0;
			query_len_q  <= '0;
			query_low_q  <= '0;
			query_high_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				nsm_pkg::REG_CASE_SENSITIVE: case_sens_q  <= pwdata[0];
				nsm_pkg::REG_QUERY_LENGTH:   query_len_q  <= pwdata[LW-1:0];
				nsm_pkg::REG_QUERY_LOW:      query_low_q  <= pwdata;
				nsm_pkg::REG_QUERY_HIGH:     query_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			nsm_pkg::REG_CASE_SENSITIVE: prdata = {63'd0, case_sens_q};
			nsm_pkg::REG_QUERY_LENGTH:   prdata = {{(64-LW){1'b0}}, query_len_q};
			nsm_pkg::REG_QUERY_LOW:      prdata = query_low_q;
			nsm_pkg::REG_QUERY_HIGH:     prdata = query_high_q;
			default:                     prdata = '0;
		endcase
	end

	// query bytes, byte 0 lowest
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			qbytes[k]     = query_low_q[8*k +: 8];
			qbytes[k + 8] = query_high_q[8*k +: 8];
		end
	end

	// overlong length counts as the full window
	assign len_c = (query_len_q > LW'(MAX_QUERY)) ? LW'(MAX_QUERY) : query_len_q;

	// ---------------------------------------------------------------- cell row
	assign accept   = s_tvalid && s_tready;
	assign chain[0] = s_tdata;

	for (genvar j = 0; j < MAX_QUERY; j++) begin : g_cell
		nsm_pkg::cell_ctrl_t ctrl;
		logic [3:0]          qidx;

		// window entry j lines up with query byte len-1-j
		assign qidx           = 4'(len_c - LW'(j) - LW'(1));
		assign ctrl.shift     = accept;
		assign ctrl.clear     = s_tlast;
		assign ctrl.case_sens = case_sens_q;
		assign ctrl.active    = LW'(j) < len_c;

		if (j < MAX_QUERY - 1) begin : g_mid
			nsm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.byte_in    (chain[j]),
				.query_byte (qbytes[qidx]),
				.byte_out   (chain[j+1]),
				.eq         (eq_vec[j])
			);
		end else begin : g_end
			// oldest byte falls off the end of the row
			nsm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.byte_in    (chain[j]),
				.query_byte (qbytes[qidx]),
				.byte_out   (),
				.eq         (eq_vec[j])
			);
		end
	end

	// ---------------------------------------------------------------- match decision
	assign seen_next = (seen_q < LW'(MAX_QUERY)) ? seen_q + LW'(1) : seen_q;

	// a match needs no pending skip, a non-empty query and enough bytes of this text
	assign hit = (skip_q == 4'd0) && (len_c != '0) && (seen_next >= len_c) && (&eq_vec);

	assign start_full = pos_q - POSITION_BITS'(len_c) + POSITION_BITS'(1);
	assign start_ext  = 64'(start_full);
	assign count_next = (hit && count_q != nsm_pkg::COUNT_MAX) ? count_q + OW'(1) : count_q;

	always_comb begin
		if (hit) begin
			skip_next = 4'(len_c - LW'(1));
		end else if (skip_q != 4'd0) begin
			skip_next = skip_q - 4'd1;
		end else begin
			skip_next = skip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			skip_q  <= '0;
			count_q <= '0;
			seen_q  <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q   <= '0;
				skip_q  <= '0;
				count_q <= '0;
				seen_q  <= '0;
			end else begin
				pos_q   <= pos_q + POSITION_BITS'(1);
				skip_q  <= skip_next;
				count_q <= count_next;
				seen_q  <= seen_next;
			end
		end
	end

	// ---------------------------------------------------------------- result buffer
	assign res_word.match = hit;
	assign res_word.start = hit ? start_ext[OW-1:0] : '0;
	assign res_word.count = count_next;
	assign res_word.eot   = s_tlast;

	nsm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_word   (res_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	assign m_tdata = {7'd0, out_word.count, out_word.start, out_word.match};
	assign m_tlast = out_word.eot;

	// ---------------------------------------------------------------- checks
	`include "nonoverlapping_substring_matcher_defines.svh"

	// input only stalls while a result is waiting
	`NSM_ASSERT_NOW(a_stall_has_result, clk, arst_n, !s_tready, m_tvalid)
	// a match with a query longer than one byte opens a skip run
	`NSM_ASSERT_NEXT(a_skip_after_hit, clk, arst_n,
		accept && hit && !s_tlast && len_c > LW'(1), skip_q != 4'd0)
	// the match count never goes down within a text
	`NSM_ASSERT_NEXT(a_count_monotonic, clk, arst_n,
		accept && !s_tlast, count_q >= $past(count_q))
	// no match while a skip is pending
	`NSM_ASSERT_NOW(a_no_hit_in_skip, clk, arst_n, skip_q != 4'd0, !hit)

endmodule

`default_nettype wire

### tb/nsm_result_checker.sv
// result checker for the non-overlapping substring matcher: follows config writes,
// predicts one result word per accepted text word and compares the master stream
// depends on nsm_pkg for the register index codes
`timescale 1ns / 100ps

module nsm_result_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [4:0]  paddr,
	input  wire [63:0] pwdata,
	input  wire        pready,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [7:0]  s_tdata,   // text_byte
	input  wire        s_tlast,   // last
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [55:0] m_tdata,   // match, match_start[23:0], match_count[23:0], zero fill
	input  wire        m_tlast,   // end_of_text
	output int         fail_count,
	output int         awaited
);

	typedef struct {
		logic        match;
		logic [23:0] start;
		logic [23:0] count;
		logic        eot;
	} scan_result_t;

	scan_result_t awaited_results [$];

	// register copies
	logic         case_exact;
	logic [4:0]   query_len;
	logic [127:0] query_bits;

	// scan state of the current text
	logic [7:0]   window [16];
	logic [23:0]  position;
	logic [3:0]   skip_left;
	logic [23:0]  match_total;
	logic [4:0]   held;

	function automatic logic [7:0] to_lower(input logic [7:0] b, input logic exact);
		if (!exact && b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	task automatic clear_text();
		foreach (window[i]) window[i] = 8'h00;
		position    = '0;
		skip_left   = '0;
		match_total = '0;
		held        = '0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic l, output scan_result_t r);
		int eff_len;
		logic hit;
		eff_len = (query_len > 16) ? 16 : query_len;
		hit = 1'b0;
		r.start = '0;
		for (int i = 15; i > 0; i--) window[i] = window[i-1];
		window[0] = b;
		if (held < 16) held++;
		if (skip_left != 0) begin
			skip_left--;
		end else if (eff_len > 0 && held >= eff_len) begin
			hit = 1'b1;
			// oldest window byte lines up with query byte 0
			for (int k = 0; k < eff_len; k++) begin
				if (to_lower(window[eff_len-1-k], case_exact) !=
						to_lower(query_bits[k*8 +: 8], case_exact)) hit = 1'b0;
			end
			if (hit) begin
				r.start   = position - 24'(eff_len - 1);
				skip_left = 4'(eff_len - 1);
				if (match_total != 24'hFFFFFF) match_total++;
			end
		end
		r.match = hit;
		r.count = match_total;
		r.eot   = l;
		position++;
		if (l) clear_text();
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t r;
		if (!arst_n) begin
			case_exact = 1'b0;
			query_len  = '0;
			query_bits = '0;
			clear_text();
			awaited_results.delete();
			fail_count = 0;
			awaited    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (nsm_pkg::reg_idx_t'(paddr[4:3]))
					nsm_pkg::REG_CASE_SENSITIVE: case_exact = pwdata[0];
					nsm_pkg::REG_QUERY_LENGTH:   query_len = pwdata[4:0];
					nsm_pkg::REG_QUERY_LOW:      query_bits[63:0] = pwdata;
					nsm_pkg::REG_QUERY_HIGH:     query_bits[127:64] = pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, s_tlast, r);
				awaited_results = {awaited_results, r};
			end
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: result word with none expected, got %h last %b",
						$time, m_tdata, m_tlast);
				end else begin
					r = awaited_results.pop_front();
					check_field("match", 24'(r.match), 24'(m_tdata[0]));
					check_field("match_start", r.start, m_tdata[24:1]);
					check_field("match_count", r.count, m_tdata[48:25]);
					check_field("end_of_text", 24'(r.eot), 24'(m_tlast));
				end
			end
			awaited = awaited_results.size();
		end
	end

endmodule

### tb/nonoverlapping_substring_matcher_tb.sv
// top of the substring matcher testbench: clock, reset, config writes, text stimulus
// depends on nsm_pkg, the matcher rtl and nsm_result_checker
`timescale 1ns / 100ps

module nonoverlapping_substring_matcher_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT     = 19;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // text_byte
	logic        s_tlast = 1'b0;  // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // match, match_start[23:0], match_count[23:0], zero fill
	logic        m_tlast;         // end_of_text

	int fail_count;
	int awaited;
	int cycles = 0;
	int sent = 0;

	// no idling on either side while this is set
	bit steady = 1'b0;

	// stimulus side copy of the query so that texts can carry it
	logic [7:0] query [16];
	logic       case_mode;
	logic [4:0] query_len;

	nonoverlapping_substring_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	nsm_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .awaited(awaited)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// two-phase apb write: setup then access, pready waited on
	task automatic apb_write(input nsm_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic cs, input logic [4:0] len,
			input logic [63:0] low, input logic [63:0] high);
		apb_write(nsm_pkg::REG_CASE_SENSITIVE, {63'd0, cs});
		apb_write(nsm_pkg::REG_QUERY_LENGTH, {59'd0, len});
		apb_write(nsm_pkg::REG_QUERY_LOW, low);
		apb_write(nsm_pkg::REG_QUERY_HIGH, high);
	endtask

	// one text word, with random idle cycles ahead of it
	task automatic send_word(input logic [7:0] b, input logic l);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// drop valid and wait until every expected result word is out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// small alphabet so that matches are common, with the odd random byte
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1:    return 8'h61;
			2, 3:    return 8'h62;
			4:       return 8'h41;
			5:       return 8'h42;
			6:       return 8'h63;
			7:       return 8'h43;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// a text of about n bytes with copies of the query planted in it
	task automatic send_text(input int n, input bit close);
		logic [7:0] text [$];
		logic [7:0] b;
		int eff_len;
		eff_len = (query_len > 16) ? 16 : query_len;
		while (text.size() < n) begin
			if (eff_len > 0 && $urandom_range(0, 99) < 25) begin
				for (int k = 0; k < eff_len; k++) begin
					b = query[k];
					// flip the case of letters when folding is on
					if (!case_mode && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A
							&& $urandom_range(0, 1))
						b = b ^ 8'h20;
					text = {text, b};
				end
			end else begin
				b = pick_byte();
				text = {text, b};
			end
		end
		foreach (text[i]) send_word(text[i], close && (i == text.size() - 1));
	endtask

	initial begin
		int r;
		int eff_len;
		logic [127:0] qbits;
		bit noisy;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: empty query, nothing may match
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		drain();

		// folding on, query "aa": non-overlapping matches and a short text at the start
		set_config(1'b0, 5'd2, 64'h6161, 64'h0);
		send_word(8'h41, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h41, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h61, 1'b1);
		drain();

		// exact compare, same query: upper case must not match
		set_config(1'b1, 5'd2, 64'h6161, 64'h0);
		send_word(8'h41, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h61, 1'b1);
		drain();

		// overlong length falls back to the full 16 bytes, all ones
		set_config(1'b0, 5'd31, '1, '1);
		for (int i = 0; i < 16; i++) send_word(8'hFF, i == 15);
		drain();

		// single zero byte query, a match at each zero byte
		set_config(1'b1, 5'd1, 64'h0, 64'h0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h5A, 1'b1);
		drain();

		// random phases; a text may stay open across a config change
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent >= 250 && sent < 400);
			r = $urandom_range(0, 19);
			case (r)
				0:       query_len = 5'd0;
				1:       query_len = 5'd16;
				2:       query_len = 5'($urandom_range(17, 31));
				3, 4:    query_len = 5'($urandom_range(5, 15));
				default: query_len = 5'($urandom_range(1, 4));
			endcase
			case_mode = 1'($urandom_range(0, 1));
			noisy = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < 16; k++) begin
				query[k] = (noisy || $urandom_range(0, 99) >= 85)
					? 8'($urandom_range(0, 255)) : pick_byte();
				qbits[k*8 +: 8] = query[k];
			end
			set_config(case_mode, query_len, qbits[63:0], qbits[127:64]);
			eff_len = (query_len > 16) ? 16 : query_len;
			repeat ($urandom_range(1, 3)) begin
				// now and then a short text of about one to three bytes
				if ($urandom_range(0, 5) == 0)
					send_text($urandom_range(1, 3), 1'b1);
				else
					send_text($urandom_range(1, 24) + eff_len, $urandom_range(0, 3) != 0);
			end
			drain();
		end
		steady = 1'b0;

		drain();
		repeat (16) @(negedge clk);
		if (fail_count == 0 && awaited == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
